/* src/assert_macros.svh */
// Assertion macros for the xtbd modules; xtbd_out is the one that includes them.
// Uses the clk and rst_n names of the module that includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Checked only while out of reset
`define XTBD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every clock edge, reset included
`define XTBD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define XTBD_ASSERT(label, prop, msg)
`define XTBD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

/* src/xtbd_pkg.sv */
// Shared types, constants and round functions for the XTEA block decipher.
// No dependencies.
`default_nettype none

package xtbd_pkg;

    localparam int unsigned WORD_W         = 32;
    localparam int unsigned DEFAULT_ROUNDS = 32;
    localparam int unsigned NUM_KEYS       = 4;
    localparam int unsigned KEY_SEL_W      = 2;
    localparam int unsigned SUM_SEL_LSB    = 11;
    localparam int unsigned CFG_IDX_W      = 8;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t XT_DELTA = 32'h9E37_79B9;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD0 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD1 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD2 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD3 = 8'd3;

    typedef logic [NUM_KEYS-1:0][WORD_W-1:0] key_t;

    // One cipher block in flight
    typedef struct packed {
        word_t second;
        word_t first;
    } blk_t;

    // delta * n, wrapped to 32 bits (elaboration only)
    function automatic word_t round_sum(input int unsigned n);
        logic [63:0] prod;
        prod = 64'(XT_DELTA) * 64'(n);
        return prod[WORD_W-1:0];
    endfunction

    // ((x << 4) ^ (x >> 5)) + x
    function automatic word_t xt_mix(input word_t x);
        return ((x << 4) ^ (x >> 5)) + x;
    endfunction

endpackage

`default_nettype wire

/* src/xtbd_cell.sv */
// One half-round of XTEA decipher: a pipeline cell with its own round key.
// Depends on xtbd_pkg.
`default_nettype none

module xtbd_cell
    import xtbd_pkg::*;
#(
    parameter word_t SUM_VAL     = XT_DELTA,
    parameter bit    SECOND_HALF = 1'b0
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire key_t key_words,
    input  wire logic in_valid,
    input  wire blk_t in_blk,
    output logic      out_valid,
    output blk_t      out_blk
);

    // First half uses sum bits 12:11, second half the low two bits
    localparam logic [KEY_SEL_W-1:0] KEY_SEL = SECOND_HALF ?
        SUM_VAL[KEY_SEL_W-1:0] : SUM_VAL[SUM_SEL_LSB +: KEY_SEL_W];

    logic  valid_reg;
    word_t t_reg;
    word_t t_next;
    blk_t  blk_reg;
    blk_t  blk_next;

    // Round key follows the key registers; reset value matches an all-zero key
    assign t_next = SUM_VAL + key_words[KEY_SEL];

    // Half-round update
    always_comb
    begin
        blk_next = in_blk;
        if (SECOND_HALF)
        begin
            blk_next.first = in_blk.first - (xt_mix(in_blk.second) ^ t_reg);
        end
        else
        begin
            blk_next.second = in_blk.second - (xt_mix(in_blk.first) ^ t_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            t_reg     <= SUM_VAL;
        end
        else
        begin
            t_reg <= t_next;
            if (en)
            begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            blk_reg <= blk_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_blk   = blk_reg;

endmodule

`default_nettype wire

/* src/xtbd_out.sv */
// Output register with skid stage; produces the chain advance enable.
// Depends on xtbd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module xtbd_out
    import xtbd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic pipe_valid,
    input  wire blk_t pipe_blk,
    output logic      en,
    output logic      m_valid,
    input  wire logic m_ready,
    output blk_t      m_blk
);

    logic out_valid_reg;
    logic out_valid_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    blk_t out_blk_reg;
    blk_t out_blk_next;
    blk_t skid_blk_reg;
    blk_t skid_blk_next;
    logic arrive;

    // Chain moves only while the skid stage is free
    assign en     = !skid_valid_reg;
    assign arrive = en && pipe_valid;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_blk_next    = out_blk_reg;
        skid_blk_next   = skid_blk_reg;
        if (out_valid_reg && !m_ready)
        begin
            // output stalled: a new result parks in the skid stage
            if (arrive)
            begin
                skid_valid_next = 1'b1;
                skid_blk_next   = pipe_blk;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_blk_next    = skid_blk_reg;
            skid_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = arrive;
            out_blk_next   = pipe_blk;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_blk_reg  <= out_blk_next;
        skid_blk_reg <= skid_blk_next;
    end

    assign m_valid = out_valid_reg;
    assign m_blk   = out_blk_reg;

    `XTBD_ASSERT_ALWAYS(a_skid_needs_out, skid_valid_reg |-> out_valid_reg, "skid full, out empty")
    `XTBD_ASSERT(a_stall_parks, out_valid_reg && !m_ready && arrive |=> skid_valid_reg, "result lost on stall")
    `XTBD_ASSERT(a_skid_drains, skid_valid_reg && m_ready |=> out_valid_reg && !skid_valid_reg, "skid not drained")

endmodule

`default_nettype wire

/* src/xtea_block_decrypt.sv */
// XTEA block decipher: a 2*ROUNDS cell half-round pipeline.
// Depends on xtbd_pkg, xtbd_cell and xtbd_out.
//
// Deciphers one 64-bit block per clock cycle under the 128-bit key held in
// configuration registers 0..3 (key word k[0]..k[3]). Each of the 2*ROUNDS
// cells does one half-round and holds its own round key (sum plus key word),
// which is registered from the key registers. A block passes through the
// 2*ROUNDS cells and then the output register; throughput is one transfer
// per cycle while the output side keeps up. The output register plus a
// one-entry skid stage let the input keep taking blocks while a result
// waits; the whole chain stalls only when both are full. Keys reset to zero
// and should be written while no block is in flight.
`default_nettype none

module xtea_block_decrypt
    import xtbd_pkg::*;
#(
    parameter int unsigned ROUNDS = DEFAULT_ROUNDS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // input stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [63:0]          s_axis_tdata,  // [31:0] cipher_first, [63:32] cipher_second
    // output stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [63:0]               m_axis_tdata,  // [31:0] plain_first, [63:32] plain_second
    // configuration writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data
);

    localparam int unsigned NUM_CELLS = 2 * ROUNDS;

    key_t key_reg;
    logic en;
    logic [NUM_CELLS:0] chain_valid;
    blk_t chain_blk [NUM_CELLS+1];
    blk_t out_blk;

    // Key registers; writes outside the list are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_KEY_WORD0: key_reg[0] <= cfg_data;
                CFG_KEY_WORD1: key_reg[1] <= cfg_data;
                CFG_KEY_WORD2: key_reg[2] <= cfg_data;
                CFG_KEY_WORD3: key_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Chain head
    assign s_axis_tready       = en;
    assign chain_valid[0]      = s_axis_tvalid;
    assign chain_blk[0].first  = s_axis_tdata[31:0];
    assign chain_blk[0].second = s_axis_tdata[63:32];

    // Half-round cells: even cells update second, odd cells update first
    for (genvar j = 0; j < NUM_CELLS; j++)
    begin : g_cell
        localparam bit HALF = bit'(j % 2);

        xtbd_cell #(
            .SUM_VAL     (round_sum(ROUNDS - (j + HALF) / 2)),
            .SECOND_HALF (HALF)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .key_words (key_reg),
            .in_valid  (chain_valid[j]),
            .in_blk    (chain_blk[j]),
            .out_valid (chain_valid[j+1]),
            .out_blk   (chain_blk[j+1])
        );
    end

    // Output register and skid stage
    xtbd_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .pipe_valid (chain_valid[NUM_CELLS]),
        .pipe_blk   (chain_blk[NUM_CELLS]),
        .en         (en),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_blk      (out_blk)
    );

    assign m_axis_tdata = {out_blk.second, out_blk.first};

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for xtea_block_decrypt: streams cipher blocks under
// several keys and compares every output transfer with a local decipher model.
// Depends on xtbd_pkg and the xtea_block_decrypt RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import xtbd_pkg::*;

    localparam int unsigned ROUNDS      = DEFAULT_ROUNDS;
    localparam int unsigned LATENCY     = 2 * ROUNDS + 1;
    localparam int unsigned MAX_REPORTS = 10;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [63:0]          s_axis_tdata  = '0;  // [31:0] cipher_first, [63:32] cipher_second
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [63:0]          m_axis_tdata;        // [31:0] plain_first, [63:32] plain_second
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [WORD_W-1:0]    cfg_data      = '0;

    // Blocks waiting to be driven, and plaintext expected on the output
    blk_t pending_blocks[$];
    blk_t expected_plain[$];

    // Key as the block should hold it
    key_t key_shadow = '0;

    // Idle control (percent chance per cycle of starting a burst)
    int   in_stall_pct  = 0;
    int   out_stall_pct = 0;
    int   in_gap        = 0;
    int   out_gap       = 0;
    logic in_taken      = 1'b0;
    int   mismatches    = 0;

    // Corner blocks, used under the zero key and the all-ones key
    blk_t corner_blocks[10] = '{
        '{second: 32'h0000_0000, first: 32'h0000_0000},
        '{second: 32'hFFFF_FFFF, first: 32'hFFFF_FFFF},
        '{second: 32'hFFFF_FFFF, first: 32'h0000_0000},
        '{second: 32'h0000_0000, first: 32'hFFFF_FFFF},
        '{second: 32'hAAAA_AAAA, first: 32'h5555_5555},
        '{second: 32'h5555_5555, first: 32'hAAAA_AAAA},
        '{second: 32'h8000_0000, first: 32'h0000_0001},
        '{second: 32'h0000_0001, first: 32'h8000_0000},
        '{second: ~XT_DELTA,     first: XT_DELTA},
        '{second: 32'h9ABC_DEF0, first: 32'h1234_5678}
    };

    xtea_block_decrypt #(
        .ROUNDS (ROUNDS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Round mixing term: ((x << 4) ^ (x >> 5)) + x, wrapping at 32 bits
    function automatic word_t feistel_mix(input word_t x);
        return ((x << 4) ^ (x >> 5)) + x;
    endfunction

    // Full XTEA decipher of one block under key k
    function automatic blk_t xtea_decipher(input blk_t c, input key_t k);
        word_t       v0;
        word_t       v1;
        word_t       sum;
        logic [63:0] prod;
        blk_t        p;
        int          r;
        v0   = c.first;
        v1   = c.second;
        prod = 64'(XT_DELTA) * 64'(ROUNDS);
        sum  = prod[WORD_W-1:0];
        for (r = 0; r < ROUNDS; r++)
        begin
            v1  = v1 - (feistel_mix(v0) ^ (sum + k[sum[SUM_SEL_LSB +: KEY_SEL_W]]));
            sum = sum - XT_DELTA;
            v0  = v0 - (feistel_mix(v1) ^ (sum + k[sum[KEY_SEL_W-1:0]]));
        end
        p.first  = v0;
        p.second = v1;
        return p;
    endfunction

    // Random word, biased toward all-zero, all-one, single-one-bit and single-zero-bit patterns
    function automatic word_t pick_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return word_t'(1) << $urandom_range(WORD_W - 1);
            3:       return ~(word_t'(1) << $urandom_range(WORD_W - 1));
            default: return $urandom();
        endcase
    endfunction

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Input driver: holds a block until its transfer, idles in bursts
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (in_gap != 0)
            begin
                in_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_blocks.size() != 0 && in_stall_pct != 0
                     && $urandom_range(99) < in_stall_pct)
            begin
                in_gap = $urandom_range(13, 0);
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_blocks.size() != 0)
            begin
                s_axis_tdata  <= pending_blocks.pop_front();
                s_axis_tvalid <= 1'b1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output ready: stalls in bursts
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (out_gap != 0)
        begin
            out_gap--;
            m_axis_tready <= 1'b0;
        end
        else if (out_stall_pct != 0 && $urandom_range(99) < out_stall_pct)
        begin
            out_gap = $urandom_range(13, 0);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: tracks key writes, predicts on input transfers,
    // checks output transfers in order
    always @(posedge clk)
    begin : result_check
        blk_t got;
        blk_t want;
        if (rst_n)
        begin
            in_taken <= s_axis_tvalid && s_axis_tready;

            // out-of-range indexes are dropped by the block
            if (cfg_valid && cfg_ready && cfg_index < NUM_KEYS)
                key_shadow[cfg_index[KEY_SEL_W-1:0]] <= cfg_data;

            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_plain.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected output transfer: plain_first %h plain_second %h",
                                 got.first, got.second);
                end
                else
                begin
                    want = expected_plain.pop_front();
                    if (got.first !== want.first || got.second !== want.second)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display(
                                "mismatch: plain_first exp %h got %h, plain_second exp %h got %h",
                                want.first, got.first, want.second, got.second);
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                expected_plain.push_back(xtea_decipher(s_axis_tdata, key_shadow));
        end
    end

    // One config write; called and returns at a falling edge, leaves valid high
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input word_t val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    // Load all four key words plus one write to an unused index
    task automatic load_key(input key_t k);
        cfg_write(CFG_KEY_WORD0, k[0]);
        cfg_write(CFG_KEY_WORD1, k[1]);
        cfg_write(CFG_KEY_WORD2, k[2]);
        cfg_write(CFG_KEY_WORD3, k[3]);
        cfg_write(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, NUM_KEYS)), $urandom());
        cfg_valid <= 1'b0;
        // let the round keys pick up the new key
        repeat (4) @(negedge clk);
    endtask

    // Wait until every block has been sent and every result checked
    task automatic drain();
        do
            @(posedge clk);
        while (pending_blocks.size() != 0 || s_axis_tvalid || expected_plain.size() != 0);
        repeat (LATENCY) @(negedge clk);
    endtask

    task automatic push_random(input int n);
        repeat (n)
            pending_blocks.push_back('{second: pick_word(), first: pick_word()});
    endtask

    task automatic push_corners();
        foreach (corner_blocks[i])
            pending_blocks.push_back(corner_blocks[i]);
    endtask

    // Test sequence
    initial
    begin
        key_t k;
        rst_n = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // key never written: all-zero key, no idling
        in_stall_pct  = 0;
        out_stall_pct = 0;
        push_corners();
        push_random(90);
        drain();

        // all-ones key, stray write to the top index
        cfg_write(8'hFF, 32'hFFFF_FFFF);
        load_key('1);
        in_stall_pct  = 10;
        out_stall_pct = 10;
        push_corners();
        push_random(90);
        drain();

        // random key, input-side idling
        for (int i = 0; i < NUM_KEYS; i++)
            k[i] = $urandom();
        load_key(k);
        in_stall_pct  = 20;
        out_stall_pct = 5;
        push_random(130);
        drain();

        // partial update: only two key words change
        cfg_write(CFG_KEY_WORD1, pick_word());
        cfg_write(CFG_KEY_WORD3, 32'h0000_0000);
        cfg_valid <= 1'b0;
        repeat (4) @(negedge clk);
        in_stall_pct  = 5;
        out_stall_pct = 25;
        push_random(130);
        drain();

        // alternating extreme key words, heavy idling on both sides
        k[0] = '1;
        k[1] = '0;
        k[2] = '1;
        k[3] = '0;
        load_key(k);
        in_stall_pct  = 30;
        out_stall_pct = 30;
        push_random(100);
        drain();

        // random key, full rate to the end
        for (int i = 0; i < NUM_KEYS; i++)
            k[i] = pick_word();
        load_key(k);
        in_stall_pct  = 0;
        out_stall_pct = 0;
        push_random(130);
        drain();

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* xtea_block_decrypt.f */
+incdir+src
src/xtbd_pkg.sv
src/xtbd_cell.sv
src/xtbd_out.sv
src/xtea_block_decrypt.sv
dv/tb_top.sv
